// ===== hw/rtl/pds_pkg.sv =====
// Shared types and constants of the process dispatch scheduler.
// No dependencies; used by the scheduler RTL and its testbench.
`default_nettype none
package pds_pkg;

  localparam int unsigned READY_DEPTH = 16;
  localparam int unsigned WAIT_DEPTH  = 16;
  localparam int unsigned RA_W = $clog2(READY_DEPTH);
  localparam int unsigned RC_W = $clog2(READY_DEPTH + 1);
  localparam int unsigned WA_W = $clog2(WAIT_DEPTH);
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned OUT_W = 40;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] btime;
    logic [7:0]  id;
  } entry_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_BLOCK = 2'd2,
    OP_WAKE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_RR   = 2'd2,
    POL_PRIO = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_RFULL    = 3'd1,
    ERR_WFULL    = 3'd2,
    ERR_ABSENT   = 3'd3,
    ERR_IDLE_BLK = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    CONT_DISP   = 2'd0,
    CONT_ROTATE = 2'd1,
    CONT_CHECK  = 2'd2
  } cont_e;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'h001,
    ST_ADV   = 12'h002,
    ST_DISP  = 12'h004,
    ST_SRD   = 12'h008,
    ST_SCMP  = 12'h010,
    ST_TRD   = 12'h020,
    ST_TWR   = 12'h040,
    ST_AFTER = 12'h080,
    ST_CHECK = 12'h100,
    ST_WRD   = 12'h200,
    ST_WCMP  = 12'h400,
    ST_FIN   = 12'h800
  } state_e;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/pds_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module pds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/process_dispatch_scheduler.sv =====
// Process dispatch scheduler: one running slot, ordered ready queue and waiting set.
// Uses pds_pkg and two pds_ram instances (ready queue, waiting set).
//
// Input stream (s_axis_*): one word per operation; tuser carries the operation,
// tdata the process id, burst time and priority, tlast closes a group of adds.
// Output stream (m_axis_*): exactly one result word per operation with the
// running process, its remaining time, the ready count and an error code.
// Config channel (cfg_*): index 0 policy, index 1 quantum; always ready.
// An add that does not close a group goes straight to the result, and a tick
// without selection skips the scan states. A selection scans the ready memory
// entry by entry (read, compare), removing an entry shifts the queue tail one
// moved entry at a time (read, write), and a wake scans the waiting memory
// entry by entry (read, compare); the single read port of each memory keeps
// these steps serial.
// One word is processed at a time; a new input word is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// Reset clears the queue count, the waiting valid bits, the running slot and
// the registers (policy 0, quantum 1); no clearing pass is needed.
// A stalled receiver holds the result; processing stops only at the next result.
`default_nettype none
module process_dispatch_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // process_id, burst_time, priority_level
  input  wire logic [1:0]  s_axis_tuser,  // operation
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // running_valid, running_id, remaining_time, ready_count, error_code, zero pad
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_addr_i,
  input  wire logic [7:0]  cfg_data_i
);

  pds_pkg::state_e state_q, state_d;
  pds_pkg::cont_e  cont_q, cont_d;
  pds_pkg::err_e   err_q, err_d;
  logic [1:0]      pol_q;
  logic [7:0]      quant_q;
  logic            run_q, run_d;
  pds_pkg::entry_t run_e_q, run_e_d;
  logic [7:0]      slice_q, slice_d;
  logic [pds_pkg::RC_W-1:0] total_q, total_d;
  logic [pds_pkg::RC_W-1:0] idx_q, idx_d;
  logic [pds_pkg::WAIT_DEPTH-1:0] wvalid_q, wvalid_d;
  logic [pds_pkg::WA_W-1:0] wi_q, wi_d;
  logic [7:0]      wid_q, wid_d;
  pds_pkg::entry_t best_q, best_d;
  logic [pds_pkg::RA_W-1:0] best_idx_q, best_idx_d;
  logic            out_valid_q, out_valid_d;
  logic [pds_pkg::OUT_W-1:0] out_data_q, out_data_d;

  logic                     rq_we;
  logic [pds_pkg::RA_W-1:0] rq_waddr, rq_raddr;
  logic [pds_pkg::ENTRY_W-1:0] rq_wdata, rq_rdata;
  logic                     wq_we;
  logic [pds_pkg::WA_W-1:0] wq_waddr, wq_raddr;
  logic [pds_pkg::ENTRY_W-1:0] wq_wdata, wq_rdata;

  logic            in_acc;
  logic [pds_pkg::WA_W-1:0] free_slot;
  logic            mode_min, mode_max, sel_take;
  pds_pkg::entry_t rd_e, wd_e, best_n, in_e;
  logic [pds_pkg::RA_W-1:0] best_idx_n;
  logic [15:0]     t_new;
  logic [7:0]      slice_new;
  logic            rot_pol;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == pds_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign rd_e = pds_pkg::entry_t'(rq_rdata);
  assign wd_e = pds_pkg::entry_t'(wq_rdata);
  assign in_e = pds_pkg::entry_t'(s_axis_tdata);
  assign rot_pol = (pol_q == pds_pkg::POL_RR) || (pol_q == pds_pkg::POL_PRIO);

  assign mode_max = (pol_q == pds_pkg::POL_PRIO);
  assign mode_min = (pol_q == pds_pkg::POL_SJF) && (cont_q == pds_pkg::CONT_DISP);
  assign sel_take = (idx_q == '0) || (mode_min && (rd_e.btime < best_q.btime)) ||
                    (mode_max && (rd_e.prio > best_q.prio));
  assign best_n     = sel_take ? rd_e : best_q;
  assign best_idx_n = sel_take ? idx_q[pds_pkg::RA_W-1:0] : best_idx_q;
  assign t_new      = run_e_q.btime - {15'd0, (run_e_q.btime != 16'd0)};
  assign slice_new  = (slice_q == 8'hFF) ? slice_q : slice_q + 8'd1;

  always_comb begin
    free_slot = '0;
    for (int i = pds_pkg::WAIT_DEPTH - 1; i >= 0; i--) begin
      if (!wvalid_q[i]) free_slot = pds_pkg::WA_W'(i);
    end
  end

  always_comb begin
    state_d     = state_q;
    cont_d      = cont_q;
    err_d       = err_q;
    run_d       = run_q;
    run_e_d     = run_e_q;
    slice_d     = slice_q;
    total_d     = total_q;
    idx_d       = idx_q;
    wvalid_d    = wvalid_q;
    wi_d        = wi_q;
    wid_d       = wid_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rq_we    = 1'b0;
    rq_waddr = total_q[pds_pkg::RA_W-1:0];
    rq_wdata = run_e_q;
    rq_raddr = idx_q[pds_pkg::RA_W-1:0];
    wq_we    = 1'b0;
    wq_waddr = free_slot;
    wq_wdata = run_e_q;
    wq_raddr = wi_q;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      pds_pkg::ST_IDLE: begin
        if (in_acc) begin
          err_d = pds_pkg::ERR_OK;
          case (pds_pkg::op_e'(s_axis_tuser))
            pds_pkg::OP_ADD: begin
              if (total_q == pds_pkg::RC_W'(pds_pkg::READY_DEPTH)) begin
                err_d   = pds_pkg::ERR_RFULL;
                state_d = pds_pkg::ST_FIN;
              end else begin
                rq_we    = 1'b1;
                rq_wdata = in_e;
                total_d  = total_q + pds_pkg::RC_W'(1);
                if (!s_axis_tlast) state_d = pds_pkg::ST_FIN;
                else if (run_q)    state_d = pds_pkg::ST_ADV;
                else               state_d = pds_pkg::ST_DISP;
              end
            end
            pds_pkg::OP_TICK: state_d = pds_pkg::ST_ADV;
            pds_pkg::OP_BLOCK: begin
              if (!run_q) begin
                err_d   = pds_pkg::ERR_IDLE_BLK;
                state_d = pds_pkg::ST_FIN;
              end else if (&wvalid_q) begin
                err_d   = pds_pkg::ERR_WFULL;
                state_d = pds_pkg::ST_FIN;
              end else begin
                wq_we               = 1'b1;
                wvalid_d[free_slot] = 1'b1;
                run_d               = 1'b0;
                run_e_d             = '0;
                state_d             = pds_pkg::ST_DISP;
              end
            end
            default: begin
              wi_d    = '0;
              wid_d   = in_e.id;
              state_d = pds_pkg::ST_WRD;
            end
          endcase
        end
      end
      pds_pkg::ST_WRD: state_d = pds_pkg::ST_WCMP;
      pds_pkg::ST_WCMP: begin
        if (wvalid_q[wi_q] && (wd_e.id == wid_q)) begin
          if (total_q == pds_pkg::RC_W'(pds_pkg::READY_DEPTH)) begin
            err_d   = pds_pkg::ERR_RFULL;
            state_d = pds_pkg::ST_FIN;
          end else begin
            rq_we          = 1'b1;
            rq_wdata       = wq_rdata;
            total_d        = total_q + pds_pkg::RC_W'(1);
            wvalid_d[wi_q] = 1'b0;
            state_d        = run_q ? pds_pkg::ST_ADV : pds_pkg::ST_DISP;
          end
        end else if (wi_q == pds_pkg::WA_W'(pds_pkg::WAIT_DEPTH - 1)) begin
          err_d   = pds_pkg::ERR_ABSENT;
          state_d = pds_pkg::ST_FIN;
        end else begin
          wi_d    = wi_q + pds_pkg::WA_W'(1);
          state_d = pds_pkg::ST_WRD;
        end
      end
      pds_pkg::ST_ADV: begin
        if (!run_q) begin
          state_d = pds_pkg::ST_FIN;
        end else begin
          run_e_d.btime = t_new;
          slice_d       = slice_new;
          if (t_new == 16'd0) begin
            run_d   = 1'b0;
            run_e_d = '0;
            state_d = pds_pkg::ST_DISP;
          end else if (rot_pol && (slice_new >= quant_q)) begin
            slice_d = '0;
            if (total_q != '0) begin
              cont_d  = pds_pkg::CONT_ROTATE;
              idx_d   = '0;
              state_d = pds_pkg::ST_SRD;
            end else begin
              state_d = pds_pkg::ST_CHECK;
            end
          end else begin
            state_d = pds_pkg::ST_CHECK;
          end
        end
      end
      pds_pkg::ST_CHECK: begin
        if ((pol_q == pds_pkg::POL_PRIO) && (total_q != '0)) begin
          cont_d  = pds_pkg::CONT_CHECK;
          idx_d   = '0;
          state_d = pds_pkg::ST_SRD;
        end else begin
          state_d = pds_pkg::ST_FIN;
        end
      end
      pds_pkg::ST_DISP: begin
        if (run_q || (total_q == '0)) begin
          state_d = pds_pkg::ST_FIN;
        end else begin
          cont_d  = pds_pkg::CONT_DISP;
          idx_d   = '0;
          state_d = pds_pkg::ST_SRD;
        end
      end
      pds_pkg::ST_SRD: state_d = pds_pkg::ST_SCMP;
      pds_pkg::ST_SCMP: begin
        best_d     = best_n;
        best_idx_d = best_idx_n;
        if ((idx_q + pds_pkg::RC_W'(1)) == total_q) begin
          idx_d = pds_pkg::RC_W'(best_idx_n);
          case (cont_q)
            pds_pkg::CONT_DISP: state_d = pds_pkg::ST_TRD;
            pds_pkg::CONT_ROTATE: begin
              if ((pol_q == pds_pkg::POL_RR) || (best_n.prio >= run_e_q.prio)) begin
                state_d = pds_pkg::ST_TRD;
              end else begin
                state_d = pds_pkg::ST_CHECK;
              end
            end
            default: begin
              state_d = (best_n.prio > run_e_q.prio) ? pds_pkg::ST_TRD : pds_pkg::ST_FIN;
            end
          endcase
        end else begin
          idx_d   = idx_q + pds_pkg::RC_W'(1);
          state_d = pds_pkg::ST_SRD;
        end
      end
      pds_pkg::ST_TRD: begin
        if ((idx_q + pds_pkg::RC_W'(1)) < total_q) begin
          rq_raddr = pds_pkg::RA_W'(idx_q + pds_pkg::RC_W'(1));
          state_d  = pds_pkg::ST_TWR;
        end else begin
          total_d = total_q - pds_pkg::RC_W'(1);
          state_d = pds_pkg::ST_AFTER;
        end
      end
      pds_pkg::ST_TWR: begin
        rq_we    = 1'b1;
        rq_waddr = idx_q[pds_pkg::RA_W-1:0];
        rq_wdata = rq_rdata;
        idx_d    = idx_q + pds_pkg::RC_W'(1);
        state_d  = pds_pkg::ST_TRD;
      end
      pds_pkg::ST_AFTER: begin
        run_d   = 1'b1;
        run_e_d = best_q;
        slice_d = '0;
        if (cont_q == pds_pkg::CONT_DISP) begin
          state_d = pds_pkg::ST_FIN;
        end else begin
          rq_we   = 1'b1;
          total_d = total_q + pds_pkg::RC_W'(1);
          if ((cont_q == pds_pkg::CONT_ROTATE) && (pol_q == pds_pkg::POL_PRIO)) begin
            state_d = pds_pkg::ST_CHECK;
          end else begin
            state_d = pds_pkg::ST_FIN;
          end
        end
      end
      pds_pkg::ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, err_q, total_q,
                         run_q ? run_e_q.btime : 16'd0,
                         run_q ? run_e_q.id : 8'd0, run_q};
          state_d     = pds_pkg::ST_IDLE;
        end
      end
      default: state_d = pds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pds_pkg::ST_IDLE;
      cont_q      <= pds_pkg::CONT_DISP;
      err_q       <= pds_pkg::ERR_OK;
      pol_q       <= pds_pkg::POL_FCFS;
      quant_q     <= 8'd1;
      run_q       <= 1'b0;
      run_e_q     <= '0;
      slice_q     <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      wvalid_q    <= '0;
      wi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cont_q      <= cont_d;
      err_q       <= err_d;
      run_q       <= run_d;
      run_e_q     <= run_e_d;
      slice_q     <= slice_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      wvalid_q    <= wvalid_d;
      wi_q        <= wi_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == pds_pkg::CFG_POLICY) pol_q <= cfg_data_i[1:0];
        else                                   quant_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wid_q      <= wid_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_data_q <= out_data_d;
  end

  pds_ram #(
    .WIDTH(pds_pkg::ENTRY_W),
    .DEPTH(pds_pkg::READY_DEPTH)
  ) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (rq_we),
    .waddr_i(rq_waddr),
    .wdata_i(rq_wdata),
    .raddr_i(rq_raddr),
    .rdata_o(rq_rdata)
  );

  pds_ram #(
    .WIDTH(pds_pkg::ENTRY_W),
    .DEPTH(pds_pkg::WAIT_DEPTH)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (wq_we),
    .waddr_i(wq_waddr),
    .wdata_i(wq_wdata),
    .raddr_i(wq_raddr),
    .rdata_o(wq_rdata)
  );

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= pds_pkg::RC_W'(pds_pkg::READY_DEPTH))
    else $error("ready count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rq_we && (state_q == pds_pkg::ST_AFTER)) |->
      (total_q < pds_pkg::RC_W'(pds_pkg::READY_DEPTH)))
    else $error("swap push into a full ready queue");

  a_take_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pds_pkg::ST_TRD) |-> (idx_q < total_q))
    else $error("take index outside the ready queue");

  a_after_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pds_pkg::ST_AFTER) |=> run_q)
    else $error("running slot empty after a take");
`endif

endmodule
`default_nettype wire

// ===== test/tb_process_dispatch_scheduler.sv =====
// Self-checking testbench for process_dispatch_scheduler: directed and random
// scheduler operations under all four policies, checked against a scoreboard.
// Depends on pds_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

class sched_scoreboard;
  pds_pkg::entry_t  rdy[pds_pkg::READY_DEPTH];
  int unsigned      rcnt;
  pds_pkg::entry_t  wt[pds_pkg::WAIT_DEPTH];
  bit               wv[pds_pkg::WAIT_DEPTH];
  pds_pkg::entry_t  run;
  bit               runp;
  int unsigned      slice;
  pds_pkg::policy_e pol;
  int unsigned      quant;
  logic [39:0]      results_due[$];
  int unsigned      errors;
  int unsigned      checked;
  int unsigned      err_seen[5];

  function new();
    rcnt = 0;
    runp = 0;
    run = '0;
    slice = 0;
    pol = pds_pkg::POL_FCFS;
    quant = 1;
    errors = 0;
    checked = 0;
    foreach (wv[i]) wv[i] = 0;
    foreach (err_seen[i]) err_seen[i] = 0;
  endfunction

  function void set_reg(logic addr, logic [7:0] val);
    if (addr == pds_pkg::CFG_POLICY) pol = pds_pkg::policy_e'(val[1:0]);
    else quant = val;
  endfunction

  function pds_pkg::entry_t take(int unsigned idx);
    pds_pkg::entry_t e;
    e = rdy[idx];
    for (int unsigned i = idx; i + 1 < rcnt; i++) rdy[i] = rdy[i + 1];
    rcnt--;
    return e;
  endfunction

  function void push(pds_pkg::entry_t e);
    if (rcnt < pds_pkg::READY_DEPTH) begin
      rdy[rcnt] = e;
      rcnt++;
    end
  endfunction

  function int unsigned top_prio_idx();
    int unsigned b;
    b = 0;
    for (int unsigned i = 1; i < rcnt; i++)
      if (rdy[i].prio > rdy[b].prio) b = i;
    return b;
  endfunction

  function int unsigned pick_idx();
    int unsigned b;
    b = 0;
    if (pol == pds_pkg::POL_PRIO) return top_prio_idx();
    if (pol == pds_pkg::POL_SJF)
      for (int unsigned i = 1; i < rcnt; i++)
        if (rdy[i].btime < rdy[b].btime) b = i;
    return b;
  endfunction

  function void dispatch();
    if (runp || rcnt == 0) return;
    run = take(pick_idx());
    runp = 1;
    slice = 0;
  endfunction

  function void swap_with(int unsigned idx);
    pds_pkg::entry_t e;
    e = take(idx);
    push(run);
    run = e;
    slice = 0;
  endfunction

  function void advance();
    int unsigned idx;
    if (!runp) return;
    if (run.btime != 0) run.btime--;
    if (slice < 255) slice++;
    if (run.btime == 0) begin
      runp = 0;
      run = '0;
      dispatch();
      return;
    end
    if ((pol == pds_pkg::POL_RR || pol == pds_pkg::POL_PRIO) && slice >= quant) begin
      slice = 0;
      if (rcnt > 0) begin
        if (pol == pds_pkg::POL_RR) begin
          swap_with(0);
        end else begin
          idx = top_prio_idx();
          if (rdy[idx].prio >= run.prio) swap_with(idx);
        end
      end
    end
    if (pol == pds_pkg::POL_PRIO && rcnt > 0) begin
      idx = top_prio_idx();
      if (rdy[idx].prio > run.prio) swap_with(idx);
    end
  endfunction

  function void note_input(pds_pkg::op_e op, logic [7:0] id, logic [15:0] bt,
                           logic [7:0] pr, logic gend);
    pds_pkg::err_e   err;
    int unsigned     slot;
    pds_pkg::entry_t e;
    err = pds_pkg::ERR_OK;
    e.id = id;
    e.btime = bt;
    e.prio = pr;
    slot = pds_pkg::WAIT_DEPTH;
    case (op)
      pds_pkg::OP_ADD: begin
        if (rcnt >= pds_pkg::READY_DEPTH) begin
          err = pds_pkg::ERR_RFULL;
        end else begin
          push(e);
          if (gend) begin
            if (runp) advance();
            else dispatch();
          end
        end
      end
      pds_pkg::OP_TICK: advance();
      pds_pkg::OP_BLOCK: begin
        if (!runp) begin
          err = pds_pkg::ERR_IDLE_BLK;
        end else begin
          for (int unsigned i = 0; i < pds_pkg::WAIT_DEPTH; i++)
            if (!wv[i]) begin
              slot = i;
              break;
            end
          if (slot == pds_pkg::WAIT_DEPTH) begin
            err = pds_pkg::ERR_WFULL;
          end else begin
            wt[slot] = run;
            wv[slot] = 1;
            runp = 0;
            run = '0;
            dispatch();
          end
        end
      end
      default: begin
        for (int unsigned i = 0; i < pds_pkg::WAIT_DEPTH; i++)
          if (wv[i] && wt[i].id == id) begin
            slot = i;
            break;
          end
        if (slot == pds_pkg::WAIT_DEPTH) begin
          err = pds_pkg::ERR_ABSENT;
        end else if (rcnt >= pds_pkg::READY_DEPTH) begin
          err = pds_pkg::ERR_RFULL;
        end else begin
          push(wt[slot]);
          wv[slot] = 0;
          if (runp) advance();
          else dispatch();
        end
      end
    endcase
    results_due.push_back({7'b0, err, 5'(rcnt), runp ? run.btime : 16'd0,
                           runp ? run.id : 8'd0, runp});
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  task check_result(logic [39:0] d);
    logic [39:0] x;
    if (results_due.size() == 0) begin
      report("unexpected result word", d[31:0], 32'd0);
      return;
    end
    x = results_due.pop_front();
    if (d[0] !== x[0]) report("running_valid", d[0], x[0]);
    if (d[8:1] !== x[8:1]) report("running_id", d[8:1], x[8:1]);
    if (d[24:9] !== x[24:9]) report("remaining_time", d[24:9], x[24:9]);
    if (d[29:25] !== x[29:25]) report("ready_count", d[29:25], x[29:25]);
    if (d[32:30] !== x[32:30]) report("error_code", d[32:30], x[32:30]);
    if (x[32:30] <= 4) err_seen[x[32:30]]++;
    checked++;
  endtask
endclass

module tb_process_dispatch_scheduler;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 105;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_addr_i;
  logic [7:0]  cfg_data_i;

  sched_scoreboard sb;
  int unsigned idle_mode;
  int unsigned hold_cycles;
  int unsigned items_sent;

  process_dispatch_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i(cfg_addr_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_op(pds_pkg::op_e op, logic [7:0] id, logic [15:0] bt,
                         logic [7:0] pr, logic gend);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {pr, bt, id};
    s_axis_tlast <= gend;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    sb.note_input(op, id, bt, pr, gend);
    items_sent++;
  endtask

  task automatic sender_gap();
    int unsigned pct;
    pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 52 : 0;
    if ($urandom_range(99) < pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(pds_pkg::policy_e pol, logic [7:0] quant);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= pds_pkg::CFG_POLICY;
    cfg_data_i <= {6'b0, pol};
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.set_reg(pds_pkg::CFG_POLICY, {6'b0, pol});
    cfg_addr_i <= pds_pkg::CFG_QUANTUM;
    cfg_data_i <= quant;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.set_reg(pds_pkg::CFG_QUANTUM, quant);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_op(int unsigned phase);
    int unsigned  roll;
    int unsigned  w_add, w_tick, w_blk;
    logic [7:0]   id;
    logic [15:0]  bt;
    logic [7:0]   pr;
    pds_pkg::op_e op;
    logic [7:0]   ids[$];
    w_add = 40; w_tick = 30; w_blk = 15;
    if (phase == 5) begin
      w_add = 45; w_tick = 5; w_blk = 40;
    end
    roll = $urandom_range(99);
    op = (roll < w_add) ? pds_pkg::OP_ADD : (roll < w_add + w_tick) ? pds_pkg::OP_TICK :
         (roll < w_add + w_tick + w_blk) ? pds_pkg::OP_BLOCK : pds_pkg::OP_WAKE;
    id = $urandom_range(255);
    roll = $urandom_range(99);
    bt = (roll < 70) ? 16'($urandom_range(1, 12)) : (roll < 85) ? 16'd0 :
         16'($urandom_range(65535));
    pr = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    if (op == pds_pkg::OP_WAKE && $urandom_range(99) < 75) begin
      foreach (sb.wv[i]) if (sb.wv[i]) ids.push_back(sb.wt[i].id);
      if (ids.size() != 0) id = ids[$urandom_range(ids.size() - 1)];
    end
    send_op(op, id, bt, pr, 1'($urandom_range(1)));
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_cycles != 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= ((idle_mode == 0) ? 52 :
                          (idle_mode == 1) ? 22 : 0));
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    pds_pkg::policy_e pols[N_PHASES];
    logic [7:0]       quants[N_PHASES];
    pols = '{pds_pkg::POL_FCFS, pds_pkg::POL_SJF, pds_pkg::POL_RR, pds_pkg::POL_RR,
             pds_pkg::POL_PRIO, pds_pkg::POL_PRIO, pds_pkg::POL_SJF, pds_pkg::POL_FCFS};
    quants = '{8'd1, 8'd7, 8'd1, 8'd255, 8'd1, 8'd3, 8'd255, 8'd200};
    sb = new();
    idle_mode = 0;
    hold_cycles = 0;
    items_sent = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= pds_pkg::OP_ADD;
    s_axis_tlast <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_addr_i <= pds_pkg::CFG_POLICY;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(pds_pkg::POL_FCFS, 8'd1);
    send_op(pds_pkg::OP_BLOCK, 8'd0, 16'd0, 8'd0, 1'b0);
    send_op(pds_pkg::OP_TICK, 8'd0, 16'd0, 8'd0, 1'b1);
    send_op(pds_pkg::OP_WAKE, 8'd255, 16'd0, 8'd0, 1'b0);
    send_op(pds_pkg::OP_ADD, 8'd0, 16'hFFFF, 8'd255, 1'b0);
    send_op(pds_pkg::OP_ADD, 8'd255, 16'd0, 8'd0, 1'b1);
    send_op(pds_pkg::OP_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
    send_op(pds_pkg::OP_BLOCK, 8'd0, 16'd0, 8'd0, 1'b0);
    send_op(pds_pkg::OP_WAKE, 8'd0, 16'd0, 8'd0, 1'b1);
    for (int i = 0; i < 16; i++)
      send_op(pds_pkg::OP_ADD, 8'(i + 16), 16'(i + 2), 8'(i % 4), 1'b0);
    send_op(pds_pkg::OP_ADD, 8'hAA, 16'h5555, 8'h5A, 1'b1);
    send_op(pds_pkg::OP_BLOCK, 8'd0, 16'd0, 8'd0, 1'b0);
    send_op(pds_pkg::OP_WAKE, 8'd0, 16'd0, 8'd0, 1'b0);

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      write_regs(pols[ph], quants[ph]);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        idle_mode = (ph * 3) / N_PHASES;
        if (n == 40 && (ph == 2 || ph == 6)) hold_cycles = 400;
        if (n == 60 && ph == 4) wait_drained();
        sender_gap();
        random_op(ph);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d operations over %0d register settings, %0d results checked",
             items_sent, N_PHASES + 1, sb.checked);
    $display("error codes seen: ok %0d rfull %0d wfull %0d absent %0d idle-block %0d",
             sb.err_seen[0], sb.err_seen[1], sb.err_seen[2], sb.err_seen[3],
             sb.err_seen[4]);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
